### hw/rtl/wsc_pkg.sv
// wake-up schedule coalescer: shared types, command and status codes, divider constants
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package wsc_pkg;

	// field widths
	localparam int TIME_W  = 48;
	localparam int ID_W    = 64;
	localparam int DELAY_W = 32;
	localparam int CMD_W   = 2;

	// millisecond values: ceil((2^TIME_W - 1) / 1000) fits in TIME_W - 9 bits
	localparam int MS_W = TIME_W - 9;

	// divide by 1000 through a reciprocal: exact for any dividend below 2^DIV_W
	localparam int DIV_W     = TIME_W + 1;
	localparam int DIV_SHIFT = DIV_W + 10;
	localparam int RECIP_W   = DIV_W + 1;
	localparam logic [127:0] RECIP_FULL = ((128'd1 << DIV_SHIFT) / 128'd1000) + 128'd1;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

	// operand split for the partial products
	localparam int XL_W   = (DIV_W + 1) / 2;
	localparam int XH_W   = DIV_W - XL_W;
	localparam int ML_W   = (RECIP_W + 1) / 2;
	localparam int MH_W   = RECIP_W - ML_W;
	localparam int PROD_W = DIV_W + RECIP_W;

	// rounding bias for the deadline ceiling
	localparam logic [DIV_W-1:0] CEIL_BIAS = DIV_W'(999);

	// command codes
	localparam logic [CMD_W-1:0] CMD_UPDATE   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_COMPLETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESET    = 2'd2;

	// status codes
	localparam logic STATUS_ISSUED    = 1'b0;
	localparam logic STATUS_EXHAUSTED = 1'b1;

	// reset values
	localparam logic [DELAY_W-1:0] MAX_DELAY_RST = DELAY_W'(60000);
	localparam logic [ID_W-1:0]    FIRST_ID      = ID_W'(1);

	// request transaction
	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic              output_pending;
		logic              deadline_valid;
		logic [TIME_W-1:0] deadline_us;
		logic [TIME_W-1:0] now_us;
		logic [ID_W-1:0]   complete_id;
	} req_t;

	// response transaction
	typedef struct packed {
		logic               status;
		logic [ID_W-1:0]    request_id;
		logic               delay_valid;
		logic [DELAY_W-1:0] delay_ms;
	} rsp_t;

	// item control carried alongside the divider pipeline
	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic             output_pending;
		logic             deadline_valid;
		logic [ID_W-1:0]  complete_id;
	} ctl_t;

endpackage

### hw/rtl/wakeup_schedule_coalescer.sv
// Wake-up schedule coalescer, top level: input register, two divide-by-1000 units, decision stage
// A result passes the input register, the partial-product and quotient registers, then the output register.
// Throughput: one request per cycle unless a waiting response stalls the output; each pipeline stage advances
// when the next one frees up, and empty stages still take new requests while a response waits.
// Reset: empties the pipeline, restarts ids at 1, clears the pending request, max delay 60000 ms.
// Depends on wsc_pkg, wsc_div1000 and wsc_core.
`timescale 1ns / 1ps

module wakeup_schedule_coalescer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  wsc_pkg::req_t               req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output wsc_pkg::rsp_t               rsp,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [wsc_pkg::DELAY_W-1:0] cfg_data
);
	import wsc_pkg::*;

	logic               valid_s1;
	logic               valid_s2;
	logic               valid_s3;
	logic               rsp_valid_q;
	ctl_t               ctl_s1;
	ctl_t               ctl_s2;
	ctl_t               ctl_s3;
	logic [DIV_W-1:0]   dl_adj_s1;
	logic [DIV_W-1:0]   now_s1;
	logic [MS_W-1:0]    dl_ms;
	logic [MS_W-1:0]    now_ms;
	logic [DELAY_W-1:0] max_delay_q;
	rsp_t               rsp_q;
	rsp_t               res;
	logic               emit;

	logic adv_s4;
	logic rdy_s3;
	logic rdy_s2;
	logic rdy_s1;
	logic en_s2;
	logic en_s3;
	logic accept;
	logic fire;

	// stage handshakes
	always_comb begin
		adv_s4 = !rsp_valid_q || rsp_ready;
		rdy_s3 = !valid_s3 || adv_s4;
		rdy_s2 = !valid_s2 || rdy_s3;
		rdy_s1 = !valid_s1 || rdy_s2;
		en_s2  = valid_s1 && rdy_s2;
		en_s3  = valid_s2 && rdy_s3;
		accept = req_valid && rdy_s1;
		fire   = valid_s3 && adv_s4;
	end

	assign req_ready = rdy_s1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= req_valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
			if (adv_s4) begin
				rsp_valid_q <= fire && emit;
			end
		end
	end

	// input register: deadline gets the ceiling bias before the divide
	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1.command        <= req.command;
			ctl_s1.output_pending <= req.output_pending;
			ctl_s1.deadline_valid <= req.deadline_valid;
			ctl_s1.complete_id    <= req.complete_id;
			dl_adj_s1             <= DIV_W'(req.deadline_us) + CEIL_BIAS;
			now_s1                <= DIV_W'(req.now_us);
		end
	end

	// control follows the divider stages
	always_ff @(posedge clk) begin
		if (en_s2) begin
			ctl_s2 <= ctl_s1;
		end
		if (en_s3) begin
			ctl_s3 <= ctl_s2;
		end
	end

	// rounded-up deadline and floored current time in milliseconds
	wsc_div1000 u_div_dl (
		.clk   (clk),
		.en_s2 (en_s2),
		.en_s3 (en_s3),
		.x     (dl_adj_s1),
		.quot  (dl_ms)
	);

	wsc_div1000 u_div_now (
		.clk   (clk),
		.en_s2 (en_s2),
		.en_s3 (en_s3),
		.x     (now_s1),
		.quot  (now_ms)
	);

	// decision and schedule state
	wsc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.ctl       (ctl_s3),
		.dl_ms     (dl_ms),
		.now_ms    (now_ms),
		.max_delay (max_delay_q),
		.emit      (emit),
		.res       (res)
	);

	// output register
	always_ff @(posedge clk) begin
		if (fire && emit) begin
			rsp_q <= res;
		end
	end

	// max delay register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_delay_q <= MAX_DELAY_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_delay_q <= cfg_data;
		end
	end

endmodule

### hw/rtl/wsc_div1000.sv
// two-stage divide by 1000 using a reciprocal split into four partial products
// depends on wsc_pkg for widths and the reciprocal constant
`timescale 1ns / 1ps

module wsc_div1000 (
	input  logic                      clk,
	input  logic                      en_s2,
	input  logic                      en_s3,
	input  logic [wsc_pkg::DIV_W-1:0] x,
	output logic [wsc_pkg::MS_W-1:0]  quot
);
	import wsc_pkg::*;

	localparam logic [ML_W-1:0] M_LO = RECIP[ML_W-1:0];
	localparam logic [MH_W-1:0] M_HI = RECIP[RECIP_W-1:ML_W];

	logic [XL_W-1:0]      x_lo;
	logic [XH_W-1:0]      x_hi;
	logic [XL_W+ML_W-1:0] p_ll_s2;
	logic [XL_W+MH_W-1:0] p_lh_s2;
	logic [XH_W+ML_W-1:0] p_hl_s2;
	logic [XH_W+MH_W-1:0] p_hh_s2;
	logic [PROD_W-1:0]    prod_sum;
	logic [MS_W-1:0]      quot_s3;

	assign x_lo = x[XL_W-1:0];
	assign x_hi = x[DIV_W-1:XL_W];

	// partial products
	always_ff @(posedge clk) begin
		if (en_s2) begin
			p_ll_s2 <= x_lo * M_LO;
			p_lh_s2 <= x_lo * M_HI;
			p_hl_s2 <= x_hi * M_LO;
			p_hh_s2 <= x_hi * M_HI;
		end
	end

	// recombine and keep the quotient bits
	assign prod_sum = PROD_W'(p_ll_s2)
		+ (PROD_W'(p_lh_s2) << ML_W)
		+ (PROD_W'(p_hl_s2) << XL_W)
		+ (PROD_W'(p_hh_s2) << (XL_W + ML_W));

	always_ff @(posedge clk) begin
		if (en_s3) begin
			quot_s3 <= prod_sum[DIV_SHIFT +: MS_W];
		end
	end

	assign quot = quot_s3;

endmodule

### hw/rtl/wsc_core.sv
// schedule state and the per-item decision: coalesce, issue, cancel, complete
// depends on wsc_pkg for types and codes
`timescale 1ns / 1ps

module wsc_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  wsc_pkg::ctl_t               ctl,
	input  logic [wsc_pkg::MS_W-1:0]    dl_ms,
	input  logic [wsc_pkg::MS_W-1:0]    now_ms,
	input  logic [wsc_pkg::DELAY_W-1:0] max_delay,
	output logic                        emit,
	output wsc_pkg::rsp_t               res
);
	import wsc_pkg::*;

	localparam int CMP_W = (MS_W > DELAY_W) ? MS_W : DELAY_W;

	logic [ID_W-1:0] next_id_q;
	logic [ID_W-1:0] pending_id_q;
	logic            immediate_q;
	logic            saved_dv_q;
	logic [MS_W-1:0] saved_dl_q;

	logic            is_update;
	logic [MS_W-1:0] dl_eff;
	logic            same_dl;
	logic            pending;
	logic            skip;
	logic            exhausted;
	logic            issue;
	logic            has_delay;
	logic [MS_W-1:0] diff;
	logic [CMP_W-1:0] diff_w;
	logic [CMP_W-1:0] max_w;
	logic [DELAY_W-1:0] delay;
	logic            clear;

	// coalescing check
	always_comb begin
		is_update = (ctl.command == CMD_UPDATE);
		dl_eff    = ctl.deadline_valid ? dl_ms : '0;
		same_dl   = (ctl.deadline_valid == saved_dv_q) &&
			(!ctl.deadline_valid || (dl_eff == saved_dl_q));
		pending   = (pending_id_q != '0);
		skip      = (pending && ((ctl.output_pending && immediate_q) ||
			(!ctl.output_pending && !immediate_q && same_dl))) ||
			(!ctl.output_pending && !ctl.deadline_valid && !pending);
		exhausted = (next_id_q == '1);
		emit      = is_update && !skip;
		issue     = emit && !exhausted;
		has_delay = ctl.output_pending || ctl.deadline_valid;
	end

	// delay: 0 if output waits or no deadline, else clamped time to deadline
	always_comb begin
		diff   = dl_eff - now_ms;
		diff_w = CMP_W'(diff);
		max_w  = CMP_W'(max_delay);
		delay  = '0;
		if (!ctl.output_pending && ctl.deadline_valid && (dl_eff > now_ms)) begin
			if (diff_w > max_w) begin
				delay = max_delay;
			end else begin
				delay = diff_w[DELAY_W-1:0];
			end
		end
	end

	// result fields
	always_comb begin
		res = '0;
		if (exhausted) begin
			res.status = STATUS_EXHAUSTED;
		end else begin
			res.status      = STATUS_ISSUED;
			res.request_id  = next_id_q;
			res.delay_valid = has_delay;
			res.delay_ms    = delay;
		end
	end

	// complete with a matching id, or an explicit reset of the pending request
	assign clear = ((ctl.command == CMD_COMPLETE) && (ctl.complete_id == pending_id_q)) ||
		(ctl.command == CMD_RESET);

	// schedule state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_id_q    <= FIRST_ID;
			pending_id_q <= '0;
			immediate_q  <= 1'b0;
			saved_dv_q   <= 1'b0;
			saved_dl_q   <= '0;
		end else if (fire) begin
			if (issue) begin
				next_id_q    <= next_id_q + ID_W'(1);
				pending_id_q <= has_delay ? next_id_q : '0;
				immediate_q  <= ctl.output_pending;
				saved_dv_q   <= ctl.deadline_valid;
				saved_dl_q   <= dl_eff;
			end else if (clear) begin
				pending_id_q <= '0;
				immediate_q  <= 1'b0;
				saved_dv_q   <= 1'b0;
				saved_dl_q   <= '0;
			end
		end
	end

endmodule
